FILE: rtl/sample_sort_bucket_classifier_macros.svh
// Assertion helpers shared by the classifier modules.
`ifndef SAMPLE_SORT_BUCKET_CLASSIFIER_MACROS_SVH
`define SAMPLE_SORT_BUCKET_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SSBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SSBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ssbc_pkg.sv
package ssbc_pkg;

	localparam int ACT_W      = 2;
	localparam int SLOT_W     = 8;
	localparam int KEY_W      = 64;
	localparam int BKT_W      = 8;
	localparam int OUT_CNT_W  = 32;
	localparam int OFF_W      = 40;
	localparam int NB_W       = 9;
	localparam int BUCKET_CAP = 256;

	localparam int MAX_BUCKETS_DEF = 256;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [NB_W-1:0]  NB_RESET = 9'd2;
	localparam logic [NB_W-1:0]  NB_MIN   = 9'd2;
	localparam logic [OFF_W-1:0] OFF_MAX  = {OFF_W{1'b1}};

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD     = 2'd0,
		ACT_CLASSIFY = 2'd1,
		ACT_QUERY    = 2'd2,
		ACT_CLEAR    = 2'd3
	} ssbc_action_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SRCH,
		F_PUSH
	} ssbc_front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_INC,
		B_QRY,
		B_DONE
	} ssbc_back_state_t;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic [SLOT_W-1:0]       slot_index;
		logic signed [KEY_W-1:0] key_value;
	} ssbc_item_t;

	typedef struct packed {
		logic [BKT_W-1:0]     bucket;
		logic [OUT_CNT_W-1:0] bucket_count;
		logic [OFF_W-1:0]     bucket_offset;
		logic                 status;
	} ssbc_result_t;

	typedef struct packed {
		ssbc_action_t     op;
		logic [BKT_W-1:0] bucket;
		logic             status;
	} ssbc_cmd_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic int cnt_depth(input int max_buckets);
		return (max_buckets < BUCKET_CAP) ? max_buckets : BUCKET_CAP;
	endfunction

endpackage

FILE: rtl/ssbc_stream_if.sv
interface ssbc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ssbc_ram.sv
module ssbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 255,
	localparam int AW = ssbc_pkg::addr_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/ssbc_front.sv
`include "sample_sort_bucket_classifier_macros.svh"

module ssbc_front #(
	parameter int MAX_BUCKETS = ssbc_pkg::MAX_BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ssbc_stream_if.sink                 items,
	input  logic [ssbc_pkg::NB_W-1:0]   nb,
	output logic                        q_push,
	output ssbc_pkg::ssbc_cmd_t         q_cmd,
	input  logic                        q_full
);
	localparam int CNT_DEPTH = ssbc_pkg::cnt_depth(MAX_BUCKETS);
	localparam int SPL_DEPTH = CNT_DEPTH - 1;
	localparam int SA        = ssbc_pkg::addr_bits(SPL_DEPTH);
	localparam int BW        = ssbc_pkg::BKT_W;

	ssbc_pkg::ssbc_front_state_t state_q, state_n;

	logic signed [ssbc_pkg::KEY_W-1:0] key_q;
	logic [BW-1:0] lo_q, hi_q, mid_q, bkt_q;
	logic [BW-1:0] lo_n, hi_n, mid_n, mid0, nsplit;

	logic                          accept;
	ssbc_pkg::ssbc_action_t        act;
	logic                          ld_err, qry_err, le;
	logic                          spl_we, spl_re;
	logic [SA-1:0]                 spl_waddr, spl_raddr;
	logic [ssbc_pkg::KEY_W-1:0]    spl_rdata;

	ssbc_ram #(
		.WIDTH(ssbc_pkg::KEY_W),
		.DEPTH(SPL_DEPTH)
	) u_spl_ram (
		.clk  (clk),
		.we   (spl_we),
		.waddr(spl_waddr),
		.wdata(items.data.key_value),
		.re   (spl_re),
		.raddr(spl_raddr),
		.rdata(spl_rdata)
	);

	assign nsplit  = BW'(nb - 9'd1);
	assign mid0    = nsplit >> 1;
	assign act     = ssbc_pkg::ssbc_action_t'(items.data.action);
	assign ld_err  = 9'(items.data.slot_index) >= (nb - 9'd1);
	assign qry_err = 9'(items.data.slot_index) >= nb;
	assign items.ready = (state_q == ssbc_pkg::F_IDLE) && !q_full;
	assign accept  = items.valid && items.ready;

	assign le   = $signed(spl_rdata) <= key_q;
	assign lo_n = le ? BW'(mid_q + 1'b1) : lo_q;
	assign hi_n = le ? hi_q : mid_q;
	assign mid_n = BW'(((BW+1)'(lo_n) + (BW+1)'(hi_n)) >> 1);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ssbc_pkg::F_IDLE: begin
				if (accept && act == ssbc_pkg::ACT_CLASSIFY) begin
					state_n = ssbc_pkg::F_SRCH;
				end
			end
			ssbc_pkg::F_SRCH: begin
				if (!(lo_n < hi_n)) begin
					state_n = ssbc_pkg::F_PUSH;
				end
			end
			ssbc_pkg::F_PUSH: begin
				if (!q_full) begin
					state_n = ssbc_pkg::F_IDLE;
				end
			end
			default: state_n = ssbc_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		q_push    = 1'b0;
		q_cmd     = '{op: ssbc_pkg::ACT_CLEAR, bucket: '0, status: ssbc_pkg::ST_OK};
		spl_we    = 1'b0;
		spl_waddr = items.data.slot_index[SA-1:0];
		spl_re    = 1'b0;
		spl_raddr = mid_n[SA-1:0];
		case (state_q)
			ssbc_pkg::F_IDLE: begin
				if (accept) begin
					case (act)
						ssbc_pkg::ACT_LOAD: begin
							q_push = 1'b1;
							q_cmd  = '{op: ssbc_pkg::ACT_LOAD, bucket: items.data.slot_index,
								status: ld_err ? ssbc_pkg::ST_RANGE : ssbc_pkg::ST_OK};
							spl_we = !ld_err;
						end
						ssbc_pkg::ACT_CLASSIFY: begin
							spl_re    = 1'b1;
							spl_raddr = mid0[SA-1:0];
						end
						ssbc_pkg::ACT_QUERY: begin
							q_push = 1'b1;
							q_cmd  = '{op: ssbc_pkg::ACT_QUERY, bucket: items.data.slot_index,
								status: qry_err ? ssbc_pkg::ST_RANGE : ssbc_pkg::ST_OK};
						end
						default: begin
							q_push = 1'b1;
						end
					endcase
				end
			end
			ssbc_pkg::F_SRCH: begin
				spl_re = lo_n < hi_n;
			end
			ssbc_pkg::F_PUSH: begin
				q_push = !q_full;
				q_cmd  = '{op: ssbc_pkg::ACT_CLASSIFY, bucket: bkt_q, status: ssbc_pkg::ST_OK};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssbc_pkg::F_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ssbc_pkg::F_IDLE && accept && act == ssbc_pkg::ACT_CLASSIFY) begin
			key_q <= items.data.key_value;
			lo_q  <= '0;
			hi_q  <= nsplit;
			mid_q <= mid0;
		end else if (state_q == ssbc_pkg::F_SRCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
			bkt_q <= lo_n;
		end
	end

	`SSBC_ASSERT_NOW(a_search_window, state_q == ssbc_pkg::F_SRCH,
		lo_q < hi_q && hi_q <= nsplit && mid_q >= lo_q && mid_q < hi_q,
		"search window out of order")
	`SSBC_ASSERT_NEXT(a_classify_starts, accept && act == ssbc_pkg::ACT_CLASSIFY,
		state_q == ssbc_pkg::F_SRCH, "classify transfer did not start a search")
endmodule

FILE: rtl/ssbc_queue.sv
`include "sample_sort_bucket_classifier_macros.svh"

module ssbc_queue #(
	parameter int DEPTH = ssbc_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssbc_pkg::ssbc_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output ssbc_pkg::ssbc_cmd_t pop_cmd,
	output logic                nonempty
);
	localparam int PW = ssbc_pkg::addr_bits(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ssbc_pkg::ssbc_cmd_t slots_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign nonempty = count_q != '0;
	assign pop_cmd  = slots_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_cmd;
		end
	end

	`SSBC_ASSERT_NOW(a_no_push_full, push, !full, "push into a full queue")
endmodule

FILE: rtl/ssbc_back.sv
`include "sample_sort_bucket_classifier_macros.svh"

module ssbc_back #(
	parameter int MAX_BUCKETS = ssbc_pkg::MAX_BUCKETS_DEF,
	parameter int COUNT_WIDTH = ssbc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  ssbc_pkg::ssbc_cmd_t q_cmd,
	output logic                q_pop,
	ssbc_stream_if.source       results
);
	localparam int CNT_DEPTH = ssbc_pkg::cnt_depth(MAX_BUCKETS);
	localparam int CA        = ssbc_pkg::addr_bits(CNT_DEPTH);
	localparam int OW        = ssbc_pkg::OFF_W;
	localparam int SW        = (COUNT_WIDTH + 1 > OW + 1) ? COUNT_WIDTH + 1 : OW + 1;

	ssbc_pkg::ssbc_back_state_t state_q, state_n;

	ssbc_pkg::ssbc_cmd_t    cmd_q;
	ssbc_pkg::ssbc_result_t out_q;
	logic                   out_vld_q;
	logic [CNT_DEPTH-1:0]   cnt_vld_q;
	logic [COUNT_WIDTH-1:0] res_cnt_q, cur, inc;
	logic [OW-1:0]          res_off_q, off_n;
	logic [SW-1:0]          sum;
	logic [CA:0]            ptr_q, slot_x;
	logic                   rd_vld_s1, rd_last_s1, rd_hit_s1;

	logic                   cnt_re, cnt_we, out_load;
	logic [CA-1:0]          cnt_raddr;
	logic [COUNT_WIDTH-1:0] cnt_rdata;

	ssbc_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(CNT_DEPTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cmd_q.bucket[CA-1:0]),
		.wdata(inc),
		.re   (cnt_re),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	assign slot_x = {1'b0, cmd_q.bucket[CA-1:0]};
	assign cur    = rd_hit_s1 ? cnt_rdata : '0;
	assign inc    = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + 1'b1;
	assign sum    = SW'(res_off_q) + SW'(cur);
	assign off_n  = (sum > SW'(ssbc_pkg::OFF_MAX)) ? ssbc_pkg::OFF_MAX : sum[OW-1:0];

	assign results.valid = out_vld_q;
	assign results.data  = out_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ssbc_pkg::B_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						ssbc_pkg::ACT_CLASSIFY: state_n = ssbc_pkg::B_INC;
						ssbc_pkg::ACT_QUERY: begin
							state_n = (q_cmd.status == ssbc_pkg::ST_RANGE) ?
								ssbc_pkg::B_DONE : ssbc_pkg::B_QRY;
						end
						default: state_n = ssbc_pkg::B_DONE;
					endcase
				end
			end
			ssbc_pkg::B_INC: state_n = ssbc_pkg::B_DONE;
			ssbc_pkg::B_QRY: begin
				if (rd_vld_s1 && rd_last_s1) begin
					state_n = ssbc_pkg::B_DONE;
				end
			end
			ssbc_pkg::B_DONE: begin
				if (out_load) begin
					state_n = ssbc_pkg::B_IDLE;
				end
			end
			default: state_n = ssbc_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		cnt_re    = 1'b0;
		cnt_raddr = ptr_q[CA-1:0];
		cnt_we    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ssbc_pkg::B_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_cmd.op == ssbc_pkg::ACT_CLASSIFY) begin
					cnt_re    = 1'b1;
					cnt_raddr = q_cmd.bucket[CA-1:0];
				end
			end
			ssbc_pkg::B_INC: cnt_we = 1'b1;
			ssbc_pkg::B_QRY: cnt_re = ptr_q <= slot_x;
			ssbc_pkg::B_DONE: out_load = !out_vld_q || results.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ssbc_pkg::B_IDLE;
			out_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			cnt_vld_q <= '0;
		end else begin
			state_q   <= state_n;
			rd_vld_s1 <= cnt_re;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			if (q_pop && q_cmd.op == ssbc_pkg::ACT_CLEAR) begin
				cnt_vld_q <= '0;
			end else if (cnt_we) begin
				cnt_vld_q[cmd_q.bucket[CA-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_re) begin
			rd_hit_s1  <= cnt_vld_q[cnt_raddr];
			rd_last_s1 <= ptr_q == slot_x;
		end
		if (q_pop) begin
			cmd_q     <= q_cmd;
			res_cnt_q <= '0;
			res_off_q <= '0;
			ptr_q     <= '0;
		end else if (state_q == ssbc_pkg::B_INC) begin
			res_cnt_q <= inc;
		end else if (state_q == ssbc_pkg::B_QRY) begin
			if (cnt_re) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (rd_last_s1) begin
					res_cnt_q <= cur;
				end else begin
					res_off_q <= off_n;
				end
			end
		end
		if (out_load) begin
			out_q <= '{bucket: cmd_q.bucket, bucket_count: ssbc_pkg::OUT_CNT_W'(res_cnt_q),
				bucket_offset: res_off_q, status: cmd_q.status};
		end
	end

	`SSBC_ASSERT_NOW(a_read_owner, rd_vld_s1,
		state_q == ssbc_pkg::B_INC || state_q == ssbc_pkg::B_QRY,
		"count read returned outside an update or a query")
	`SSBC_ASSERT_NEXT(a_inc_writes, state_q == ssbc_pkg::B_INC,
		cnt_vld_q[$past(cmd_q.bucket[CA-1:0])], "incremented count left unmarked")
endmodule

FILE: rtl/sample_sort_bucket_classifier.sv
// Sample-sort bucket classifier. Items carry an action: load writes a splitter, classify
// bins a signed 64-bit key by binary search over the splitters in use and bumps that
// bucket's saturating count, query returns a bucket's count and its exclusive prefix sum,
// clear zeroes all counts. Every item gives one result. A front end takes items and runs
// the search one probe per cycle through the splitter RAM, so a classify holds the input
// until its result is queued; load, query and clear go straight to the queue. A two-entry
// command queue feeds the back end, which owns the count RAM through a single read port:
// a classify reads its bucket's count and writes it back incremented, a query of bucket b
// reads counts 0 to b (one count summed per cycle), load, clear and rejected queries read
// none; each result then goes into the output register. Counts reset and clear at once
// through per-bucket valid flags, with no sweep. Splitters must be loaded before a
// classify reads them and write the bucket total only while idle.
module sample_sort_bucket_classifier #(
	parameter int MAX_BUCKETS = ssbc_pkg::MAX_BUCKETS_DEF,
	parameter int COUNT_WIDTH = ssbc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ssbc_stream_if.sink               items,
	ssbc_stream_if.source             results,
	input  logic                      cfg_we,
	input  logic [ssbc_pkg::NB_W-1:0] cfg_wdata
);
	localparam int CNT_DEPTH = ssbc_pkg::cnt_depth(MAX_BUCKETS);
	localparam logic [ssbc_pkg::NB_W-1:0] NB_LIM = ssbc_pkg::NB_W'(CNT_DEPTH);

	logic [ssbc_pkg::NB_W-1:0] bkt_total_q, nb;
	logic                      q_push, q_full, q_pop, q_valid;
	ssbc_pkg::ssbc_cmd_t       q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_total_q <= ssbc_pkg::NB_RESET;
		end else if (cfg_we) begin
			bkt_total_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (bkt_total_q < ssbc_pkg::NB_MIN) begin
			nb = ssbc_pkg::NB_MIN;
		end else if (bkt_total_q > NB_LIM) begin
			nb = NB_LIM;
		end else begin
			nb = bkt_total_q;
		end
	end

	ssbc_front #(
		.MAX_BUCKETS(MAX_BUCKETS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.items (items),
		.nb    (nb),
		.q_push(q_push),
		.q_cmd (q_in),
		.q_full(q_full)
	);

	ssbc_queue #(
		.DEPTH(ssbc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_in),
		.full    (q_full),
		.pop     (q_pop),
		.pop_cmd (q_out),
		.nonempty(q_valid)
	);

	ssbc_back #(
		.MAX_BUCKETS(MAX_BUCKETS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_cmd  (q_out),
		.q_pop  (q_pop),
		.results(results)
	);
endmodule

FILE: test/tb_sample_sort_bucket_classifier.sv
module tb_sample_sort_bucket_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import ssbc_pkg::*;

	localparam int unsigned WATCHDOG = 4000;
	localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [NB_W-1:0] cfg_wdata;

	ssbc_stream_if #(.payload_t(ssbc_item_t)) item_ch ();
	ssbc_stream_if #(.payload_t(ssbc_result_t)) res_ch ();

	sample_sort_bucket_classifier uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch),
		.results   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ssbc_item_t   staged_items[$];
	ssbc_result_t awaited_outcomes[$];
	ssbc_result_t seen, want;

	// predictor state
	logic signed [KEY_W-1:0] split_mem [0:BUCKET_CAP-2];
	logic [OUT_CNT_W-1:0]    count_mem [0:BUCKET_CAP-1];
	logic [NB_W-1:0]         nb_reg;

	// stimulus-side view of the splitters
	logic [KEY_W-1:0] gen_split [0:BUCKET_CAP-2];
	int unsigned      gen_nb;

	int unsigned gap_left, stall_left, idle_cycles;
	int unsigned errors = 0;
	bit          calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned clamp_buckets(logic [NB_W-1:0] v);
		if (v < NB_MIN)
			return NB_MIN;
		if (v > BUCKET_CAP)
			return BUCKET_CAP;
		return v;
	endfunction

	function automatic ssbc_result_t bucket_outcome(ssbc_item_t it);
		ssbc_result_t r;
		int unsigned nb, lo, hi, mid, i;
		logic [47:0] acc;
		nb = clamp_buckets(nb_reg);
		r = '0;
		r.status = ST_OK;
		case (ssbc_action_t'(it.action))
			ACT_LOAD: begin
				r.bucket = it.slot_index;
				if (it.slot_index < nb - 1)
					split_mem[it.slot_index] = it.key_value;
				else
					r.status = ST_RANGE;
			end
			ACT_CLASSIFY: begin
				lo = 0;
				hi = nb - 1;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if ($signed(split_mem[mid]) <= $signed(it.key_value))
						lo = mid + 1;
					else
						hi = mid;
				end
				if (count_mem[lo] != '1)
					count_mem[lo] = count_mem[lo] + 1'b1;
				r.bucket = 8'(lo);
				r.bucket_count = count_mem[lo];
			end
			ACT_QUERY: begin
				r.bucket = it.slot_index;
				if (it.slot_index < nb) begin
					r.bucket_count = count_mem[it.slot_index];
					acc = '0;
					for (i = 0; i < it.slot_index; i++) begin
						acc = acc + count_mem[i];
						if (acc > OFF_MAX)
							acc = OFF_MAX;
					end
					r.bucket_offset = acc[OFF_W-1:0];
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: begin
				foreach (count_mem[i])
					count_mem[i] = '0;
			end
		endcase
		return r;
	endfunction

	function automatic int unsigned idle_span();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [KEY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] s;
		int unsigned r;
		s = gen_split[$urandom_range(0, gen_nb - 2)];
		r = $urandom_range(0, 99);
		if (r < 30)
			return rand64();
		if (r < 60)
			return s;
		if (r < 75)
			return s + 1'b1;
		if (r < 88)
			return s - 1'b1;
		if (r < 94)
			return KEY_MIN;
		return KEY_MAX;
	endfunction

	task automatic stage(ssbc_action_t act, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key);
		ssbc_item_t it;
		it.action = act;
		it.slot_index = slot;
		it.key_value = key;
		staged_items.push_back(it);
		if (act == ACT_LOAD && slot < gen_nb - 1)
			gen_split[slot] = key;
	endtask

	// Ascending in unsigned space, then flip the sign bit to get ascending signed keys.
	task automatic stage_ascending_splitters();
		logic [KEY_W-1:0] stride, base, u;
		int unsigned shift, i;
		bit ends;
		shift = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
		stride = ({KEY_W{1'b1}} / gen_nb) >> shift;
		if (stride == 0)
			stride = 1;
		base = (shift == 0) ? '0 : (rand64() >> 1);
		ends = ($urandom_range(0, 5) == 0);
		u = '0;
		for (i = 0; i < gen_nb - 1; i++) begin
			if (i == 0 || $urandom_range(0, 9) != 0)
				u = base + stride * i + rand64() % stride;
			if (ends && i == 0)
				u = '0;
			if (ends && i == gen_nb - 2)
				u = '1;
			stage(ACT_LOAD, 8'(i), u ^ KEY_MIN);
		end
	endtask

	task automatic stage_random_mix(int unsigned n);
		int unsigned k, r, slot;
		logic [KEY_W-1:0] key;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				stage(ACT_CLASSIFY, 8'($urandom), pick_key());
			end else if (r < 80) begin
				if (gen_nb < BUCKET_CAP && $urandom_range(0, 4) == 0)
					slot = $urandom_range(gen_nb, BUCKET_CAP - 1);
				else
					slot = $urandom_range(0, gen_nb - 1);
				stage(ACT_QUERY, 8'(slot), rand64());
			end else if (r < 98) begin
				if ($urandom_range(0, 3) == 0)
					slot = $urandom_range(gen_nb - 1, BUCKET_CAP - 1);
				else
					slot = $urandom_range(0, gen_nb - 2);
				key = rand64();
				// mostly keep the table ordered by copying a neighbor
				if (slot < gen_nb - 1 && $urandom_range(0, 2) != 0) begin
					if (slot > 0 && $urandom_range(0, 1) == 1)
						key = gen_split[slot - 1];
					else if (slot + 2 < gen_nb)
						key = gen_split[slot + 1];
					else
						key = gen_split[slot];
				end
				stage(ACT_LOAD, 8'(slot), key);
			end else begin
				stage(ACT_CLEAR, 8'($urandom), rand64());
			end
		end
	endtask

	task automatic wait_quiet();
		while (staged_items.size() != 0 || item_ch.valid || awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bucket_total(logic [NB_W-1:0] v);
		wait_quiet();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		nb_reg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_nb = clamp_buckets(v);
	endtask

	task automatic compare_field(string field, logic [63:0] exp_val, logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk)
		if ($urandom_range(0, 149) == 0)
			calm <= ~calm;

	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			gap_left <= 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (gap_left != 0) begin
				item_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (staged_items.size() != 0) begin
				item_ch.valid <= 1'b1;
				item_ch.data <= staged_items.pop_front();
				gap_left <= idle_span();
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= idle_span();
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				awaited_outcomes.push_back(bucket_outcome(item_ch.data));
			if (res_ch.valid && res_ch.ready) begin
				seen = res_ch.data;
				if (awaited_outcomes.size() == 0) begin
					$error("unexpected result: bucket %0d count %0d offset %0d status %0d",
						seen.bucket, seen.bucket_count, seen.bucket_offset, seen.status);
					errors++;
				end else begin
					want = awaited_outcomes.pop_front();
					compare_field("bucket", want.bucket, seen.bucket);
					compare_field("bucket_count", want.bucket_count, seen.bucket_count);
					compare_field("bucket_offset", want.bucket_offset, seen.bucket_offset);
					compare_field("status", want.status, seen.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [NB_W-1:0] totals [$];
		int unsigned p;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		res_ch.ready = 1'b0;
		nb_reg = NB_RESET;
		gen_nb = clamp_buckets(NB_RESET);
		foreach (count_mem[i])
			count_mem[i] = '0;
		foreach (split_mem[i])
			split_mem[i] = '0;
		foreach (gen_split[i])
			gen_split[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// two buckets after reset, one splitter
		stage(ACT_QUERY, 8'd0, rand64());
		stage(ACT_QUERY, 8'd1, rand64());
		stage(ACT_QUERY, 8'd2, rand64());
		stage(ACT_QUERY, 8'hFF, rand64());
		stage(ACT_LOAD, 8'd1, rand64());
		stage(ACT_LOAD, 8'hFF, '1);
		stage(ACT_LOAD, 8'd0, '0);
		stage(ACT_CLASSIFY, 8'hFF, KEY_MIN);
		stage(ACT_CLASSIFY, 8'd0, KEY_MAX);
		stage(ACT_CLASSIFY, 8'd0, '0);
		stage(ACT_CLASSIFY, 8'd0, '1);
		stage(ACT_QUERY, 8'd1, '0);
		stage(ACT_CLEAR, 8'hFF, '1);
		stage(ACT_QUERY, 8'd1, '0);
		stage(ACT_QUERY, 8'd0, '0);
		stage(ACT_LOAD, 8'd0, KEY_MAX);
		stage(ACT_CLASSIFY, 8'd0, KEY_MAX);
		stage(ACT_CLASSIFY, 8'd0, KEY_MAX - 1'b1);
		stage(ACT_LOAD, 8'd0, KEY_MIN);
		stage(ACT_CLASSIFY, 8'd0, KEY_MIN);
		stage(ACT_CLASSIFY, 8'd0, rand64());
		stage(ACT_QUERY, 8'd0, '0);
		stage(ACT_QUERY, 8'd1, '0);

		totals = '{9'd0, 9'd3, 9'd256, 9'd1, 9'd5, 9'd511, 9'd17,
			9'($urandom_range(4, 64)), 9'($urandom_range(4, 64)),
			9'($urandom_range(4, 64)), 9'd128, 9'd2};
		for (p = 0; p < totals.size(); p++) begin
			write_bucket_total(totals[p]);
			stage_ascending_splitters();
			stage_random_mix(50);
		end

		wait_quiet();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
